FILE: hdl/ccs_pkg.sv
// shared types, constants and helpers for the causal conv1d silu block
package ccs_pkg;

	localparam int CHANNELS_DEF   = 256;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS      = 12;
	localparam int ACC_W          = 64;

	// input queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int QP_W    = $clog2(Q_DEPTH);

	// silu datapath widths
	localparam int ZP_W  = 49;          // -a (19 bits) times log2(e) (30 bits)
	localparam int Z_W   = ZP_W - 24;   // z in Q.16
	localparam int N_W   = 8;           // integer part of z
	localparam int F_W   = 17;          // fraction of z, Q.16 within one half
	localparam int T_W   = 32;          // horner terms, Q.30
	localparam int M_W   = F_W + T_W;   // horner products
	localparam int MAG_W = 17;          // magnitude of a below the silu limit
	localparam int D_W   = 62;          // denominator, Q.30
	localparam int NUM_W = D_W + 1;     // rounded numerator
	localparam int DEN_W = D_W + 1;     // doubled denominator
	localparam int Q_W   = MAG_W + 1;   // quotient bits
	localparam int REM_W = DEN_W + Q_W;

	localparam logic signed [29:0]      LOG2E_Q28 = 30'sd387270501;
	localparam logic signed [T_W-1:0]   POLY_C1   = 32'sd744261139;
	localparam logic signed [T_W-1:0]   POLY_C2   = 32'sd257941240;
	localparam logic signed [T_W-1:0]   POLY_C3   = 32'sd59597074;
	localparam logic signed [T_W-1:0]   POLY_C4   = 32'sd10327356;
	localparam logic signed [T_W-1:0]   ONE_Q30   = 32'sd1073741824;
	localparam logic signed [ACC_W-1:0] SILU_LIM  = 64'sd131072;

	// classified item as it sits in the queue
	typedef struct packed {
		logic [7:0] ch;
		logic       ok;
	} ctl_t;

	// per item control carried down the back pipeline
	typedef struct packed {
		logic [7:0] ch;
		logic       zero;
		logic       pos;
		logic       neg;
	} meta_t;

	// signed add clamped to the 64-bit range
	function automatic logic signed [ACC_W-1:0] sat_add64(input logic signed [ACC_W-1:0] x,
			input logic signed [ACC_W-1:0] y);
		logic signed [ACC_W:0] s;
		s = (ACC_W+1)'(x) + (ACC_W+1)'(y);
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end
		return s[ACC_W-1:0];
	endfunction

endpackage

FILE: hdl/ccs_front.sv
// front end: accepts items, checks the channel range and queues them
module ccs_front import ccs_pkg::*; #(
	parameter int CHANNELS   = CHANNELS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                channel,
	input  logic [DATA_WIDTH-1:0]     sample,
	input  logic [DATA_WIDTH-1:0]     weight_oldest,
	input  logic [DATA_WIDTH-1:0]     weight_middle,
	input  logic [DATA_WIDTH-1:0]     weight_recent,
	input  logic [DATA_WIDTH-1:0]     weight_current,
	input  logic                      busy,
	output logic                      q_valid,
	output ctl_t                      q_ctl,
	output logic [5*DATA_WIDTH-1:0]   q_data,
	input  logic                      q_pop
);

	logic [5*DATA_WIDTH-1:0] data_q [Q_DEPTH];
	ctl_t                    ctl_q [Q_DEPTH];
	logic [QP_W-1:0]         wr_ptr_q, rd_ptr_q;
	logic [QP_W:0]           cnt_q;
	logic                    push;

	// accept while the queue has room and the history is not being cleared
	assign in_ready = (cnt_q != (QP_W+1)'(Q_DEPTH)) && !busy;
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_ctl    = ctl_q[rd_ptr_q];
	assign q_data   = data_q[rd_ptr_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !q_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && q_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	// queue storage, channel range check on entry
	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= {weight_current, weight_recent, weight_middle, weight_oldest,
				sample};
			ctl_q[wr_ptr_q]  <= '{ch: channel, ok: (32'(channel) < 32'(CHANNELS))};
		end
	end

endmodule

FILE: hdl/ccs_hist.sv
// per channel sample history memory with a clearing pass after reset
module ccs_hist import ccs_pkg::*; #(
	parameter int CHANNELS   = CHANNELS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] rd_idx,
	output logic [3*DATA_WIDTH-1:0]   rd_data,
	input  logic                      wr_en,
	input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] wr_idx,
	input  logic [3*DATA_WIDTH-1:0]   wr_data,
	output logic                      busy
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [3*DATA_WIDTH-1:0] mem [CHANNELS];
	logic [3*DATA_WIDTH-1:0] rd_data_q;
	logic [IDX_W-1:0]        clr_q;
	logic                    busy_q;

	assign busy    = busy_q;
	assign rd_data = rd_data_q;

	// clearing sweep, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == IDX_W'(CHANNELS - 1)) busy_q <= 1'b0;
			clr_q <= clr_q + 1'b1;
		end
	end

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (busy_q) mem[clr_q] <= '0;
		else if (wr_en) mem[wr_idx] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_idx];
	end

endmodule

FILE: hdl/ccs_div.sv
// pipelined restoring divider, one quotient bit per stage
module ccs_div import ccs_pkg::*; #(
	parameter int AUX_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [AUX_W-1:0] aux,
	output logic             out_valid,
	output logic [Q_W-1:0]   quo,
	output logic [AUX_W-1:0] aux_out
);

	logic [REM_W-1:0] r_in [Q_W];
	logic [REM_W-1:0] trial [Q_W];
	logic [REM_W-1:0] rem_q [Q_W];
	logic [DEN_W-1:0] d_in [Q_W];
	logic [DEN_W-1:0] den_q [Q_W];
	logic [Q_W-1:0]   q_in [Q_W];
	logic [Q_W-1:0]   quo_q [Q_W];
	logic [AUX_W-1:0] a_in [Q_W];
	logic [AUX_W-1:0] aux_q [Q_W];
	logic [Q_W-1:0]   ge;
	logic [Q_W-1:0]   v_q;

	// stage inputs and trial subtractions
	always_comb begin
		r_in[0] = REM_W'(num);
		d_in[0] = den;
		q_in[0] = '0;
		a_in[0] = aux;
		for (int j = 1; j < Q_W; j++) begin
			r_in[j] = rem_q[j-1];
			d_in[j] = den_q[j-1];
			q_in[j] = quo_q[j-1];
			a_in[j] = aux_q[j-1];
		end
		for (int j = 0; j < Q_W; j++) begin
			trial[j] = REM_W'(d_in[j]) << (Q_W - 1 - j);
			ge[j]    = (r_in[j] >= trial[j]);
		end
	end

	// valid shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[Q_W-2:0], in_valid};
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < Q_W; j++) begin
				rem_q[j] <= ge[j] ? (r_in[j] - trial[j]) : r_in[j];
				quo_q[j] <= q_in[j] | (ge[j] ? (Q_W'(1) << (Q_W - 1 - j)) : '0);
				den_q[j] <= d_in[j];
				aux_q[j] <= a_in[j];
			end
		end
	end

	assign out_valid = v_q[Q_W-1];
	assign quo       = quo_q[Q_W-1];
	assign aux_out   = aux_q[Q_W-1];

endmodule

FILE: hdl/ccs_back.sv
// back end: history lookup, tap sum, silu pipeline and output register
module ccs_back import ccs_pkg::*; #(
	parameter int CHANNELS   = CHANNELS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  ctl_t                          q_ctl,
	input  logic [5*DATA_WIDTH-1:0]       q_data,
	output logic                          q_pop,
	output logic                          busy,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    channel_out,
	output logic signed [DATA_WIDTH-1:0]  activation
);

	localparam int DW    = DATA_WIDTH;
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int LAST  = 16;
	localparam int AUX_W = $bits(meta_t) + DW;
	localparam logic signed [ACC_W-1:0] OUT_MAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
	localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - 64'sd1;

	function automatic logic signed [DW-1:0] sat_out(input logic signed [ACC_W-1:0] v);
		if (v > OUT_MAX) return OUT_MAX[DW-1:0];
		if (v < OUT_MIN) return OUT_MIN[DW-1:0];
		return v[DW-1:0];
	endfunction

	logic                      en;
	logic [LAST:1]             v_q;
	meta_t                     meta_q [1:LAST];
	logic [MAG_W-1:0]          mag_q [6:LAST];
	logic signed [DW-1:0]      as_q [6:LAST];

	// s1 .. s5 tap sum
	logic [5*DW-1:0]           data_s1;
	logic [3*DW-1:0]           hist_rd, hist_s1, hist_new, hist_s2;
	logic signed [DW-1:0]      x_s1, wo_s1, wm_s1, wr_s1, wc_s1, h0_s1, h1_s1, h2_s1;
	logic                      fwd;
	logic                      wr_en;
	logic signed [2*DW-1:0]    p0_s2, p1_s2, p2_s2, p3_s2, p2_s3, p3_s3, p3_s4;
	logic signed [ACC_W-1:0]   acc01_s3, acc012_s4, acc_s5;

	// s5 .. s16 silu
	logic signed [ACC_W-1:0]   a5;
	logic signed [18:0]        a19, neg_a, abs_a;
	logic                      big_pos, big_neg;
	meta_t                     meta6, meta16;
	logic signed [ZP_W-1:0]    zp5, zp_s6;
	logic signed [Z_W-1:0]     z6;
	logic signed [Z_W:0]       zr_pos, zr_neg, nw, fw;
	logic signed [N_W-1:0]     n_q [7:15];
	logic signed [F_W-1:0]     f_q [7:13];
	logic signed [M_W-1:0]     m_s8, m_s10, m_s12, m_s14;
	logic signed [T_W-1:0]     t_s9, t_s11, t_s13, p_s15;
	logic [30:0]               pu;
	logic [N_W-1:0]            nsh;
	logic [D_W-1:0]            sh15, d15, d_s16;
	logic                      n_big;
	logic [NUM_W-1:0]          num16;
	logic [DEN_W-1:0]          den16;

	// divider and output
	logic                      div_v;
	logic [Q_W-1:0]            div_q;
	logic [AUX_W-1:0]          div_aux;
	meta_t                     meta_o;
	logic signed [DW-1:0]      as_o;
	logic signed [ACC_W-1:0]   qs, res;
	logic signed [DW-1:0]      act_o;
	logic                      out_valid_q;
	logic [7:0]                ch_q;
	logic signed [DW-1:0]      act_q;

	// the whole back pipeline moves when the output register can take an item
	assign en    = !out_valid_q || out_ready;
	assign q_pop = en && q_valid && !busy;

	ccs_hist #(
		.CHANNELS  (CHANNELS),
		.DATA_WIDTH(DATA_WIDTH)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (en),
		.rd_idx (IDX_W'(q_ctl.ch)),
		.rd_data(hist_rd),
		.wr_en  (wr_en),
		.wr_idx (IDX_W'(meta_q[1].ch)),
		.wr_data(hist_new),
		.busy   (busy)
	);

	// s1 unpack, forward the history written one item earlier
	assign x_s1  = data_s1[DW-1:0];
	assign wo_s1 = data_s1[2*DW-1:DW];
	assign wm_s1 = data_s1[3*DW-1:2*DW];
	assign wr_s1 = data_s1[4*DW-1:3*DW];
	assign wc_s1 = data_s1[5*DW-1:4*DW];
	assign fwd   = v_q[2] && !meta_q[2].zero && (meta_q[2].ch == meta_q[1].ch);
	assign hist_s1  = fwd ? hist_s2 : hist_rd;
	assign h0_s1    = hist_s1[DW-1:0];
	assign h1_s1    = hist_s1[2*DW-1:DW];
	assign h2_s1    = hist_s1[3*DW-1:2*DW];
	assign hist_new = {x_s1, h2_s1, h1_s1};
	assign wr_en    = en && v_q[1] && !meta_q[1].zero;

	// s5 scale, range check and start of exp argument
	always_comb begin
		a5      = acc_s5 >>> FRAC_BITS;
		big_pos = (a5 >= SILU_LIM);
		big_neg = (a5 <= -SILU_LIM);
		a19     = a5[18:0];
		neg_a   = -a19;
		abs_a   = a19[18] ? neg_a : a19;
		zp5     = neg_a * LOG2E_Q28;
		meta6      = meta_q[5];
		meta6.zero = meta_q[5].zero | big_neg;
		meta6.pos  = big_pos & !meta_q[5].zero;
		meta6.neg  = a19[18];
	end

	// s6 split z into rounded integer and fraction
	always_comb begin
		z6     = zp_s6[ZP_W-1:24];
		zr_pos = (Z_W+1)'(z6) + (Z_W+1)'(32768);
		zr_neg = (Z_W+1)'(32768) - (Z_W+1)'(z6);
		nw     = z6[Z_W-1] ? -(zr_neg >>> 16) : (zr_pos >>> 16);
		fw     = (Z_W+1)'(z6) - (nw <<< 16);
	end

	// s15 denominator 1 + p * 2^n
	always_comb begin
		pu     = p_s15[30:0];
		nsh    = n_q[15][N_W-1] ? N_W'(-n_q[15]) : N_W'(n_q[15]);
		sh15   = (n_q[15] <= 8'sd0) ? (D_W'(pu) >> nsh) : (D_W'(pu) << nsh);
		d15    = D_W'(ONE_Q30) + sh15;
		n_big  = (n_q[15] > 8'sd30);
		meta16      = meta_q[15];
		meta16.zero = meta_q[15].zero | (n_big & !meta_q[15].pos);
	end

	// s16 rounded division operands
	assign num16 = NUM_W'({mag_q[LAST], 31'b0}) + NUM_W'(d_s16);
	assign den16 = {d_s16, 1'b0};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q[1]      <= q_valid && !busy;
			v_q[LAST:2] <= v_q[LAST-1:1];
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (en) begin
			data_s1   <= q_data;
			meta_q[1] <= '{ch: q_ctl.ch, zero: !q_ctl.ok, pos: 1'b0, neg: 1'b0};
			for (int k = 2; k <= 5; k++) meta_q[k] <= meta_q[k-1];
			meta_q[6] <= meta6;
			for (int k = 7; k <= 15; k++) meta_q[k] <= meta_q[k-1];
			meta_q[LAST] <= meta16;

			// tap products and saturating sum
			hist_s2   <= hist_new;
			p0_s2     <= wo_s1 * h0_s1;
			p1_s2     <= wm_s1 * h1_s1;
			p2_s2     <= wr_s1 * h2_s1;
			p3_s2     <= wc_s1 * x_s1;
			acc01_s3  <= sat_add64(ACC_W'(p0_s2), ACC_W'(p1_s2));
			p2_s3     <= p2_s2;
			p3_s3     <= p3_s2;
			acc012_s4 <= sat_add64(acc01_s3, ACC_W'(p2_s3));
			p3_s4     <= p3_s3;
			acc_s5    <= sat_add64(acc012_s4, ACC_W'(p3_s4));

			// silu side data
			zp_s6    <= zp5;
			mag_q[6] <= abs_a[MAG_W-1:0];
			as_q[6]  <= sat_out(a5);
			for (int k = 7; k <= LAST; k++) begin
				mag_q[k] <= mag_q[k-1];
				as_q[k]  <= as_q[k-1];
			end
			n_q[7] <= nw[N_W-1:0];
			f_q[7] <= fw[F_W-1:0];
			for (int k = 8; k <= 15; k++) n_q[k] <= n_q[k-1];
			for (int k = 8; k <= 13; k++) f_q[k] <= f_q[k-1];

			// horner steps, product then add
			m_s8  <= f_q[7] * POLY_C4;
			t_s9  <= T_W'(m_s8 >>> 16) + POLY_C3;
			m_s10 <= f_q[9] * t_s9;
			t_s11 <= T_W'(m_s10 >>> 16) + POLY_C2;
			m_s12 <= f_q[11] * t_s11;
			t_s13 <= T_W'(m_s12 >>> 16) + POLY_C1;
			m_s14 <= f_q[13] * t_s13;
			p_s15 <= T_W'(m_s14 >>> 16) + ONE_Q30;
			d_s16 <= d15;
		end
	end

	ccs_div #(
		.AUX_W(AUX_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_q[LAST]),
		.num      (num16),
		.den      (den16),
		.aux      ({meta_q[LAST], as_q[LAST]}),
		.out_valid(div_v),
		.quo      (div_q),
		.aux_out  (div_aux)
	);

	// sign, special cases and saturation
	always_comb begin
		meta_o = meta_t'(div_aux[AUX_W-1:DW]);
		as_o   = div_aux[DW-1:0];
		qs     = ACC_W'(div_q);
		res    = meta_o.neg ? -qs : qs;
		if (meta_o.zero) act_o = '0;
		else if (meta_o.pos) act_o = as_o;
		else act_o = sat_out(res);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= div_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch_q  <= meta_o.ch;
			act_q <= act_o;
		end
	end

	assign out_valid   = out_valid_q;
	assign channel_out = ch_q;
	assign activation  = act_q;

endmodule

FILE: hdl/causal_conv1d_silu.sv
// top level of the causal depthwise conv1d with silu activation
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------------
//  input    | in        | in_valid / in_ready  | channel, sample, weight_oldest..current
//  result   | out       | out_valid / out_ready| channel_out, activation
//
// one item per cycle sustained while the output is not stalled
// a result passes through the queue, the 16 stage tap and exp pipeline, the 18 stage divider and the output register
// after reset the history memory is cleared, one entry a cycle;
// in_ready stays low during that pass
// a stalled output freezes the back pipeline; the 4 entry queue keeps taking items while it has room
module causal_conv1d_silu import ccs_pkg::*; #(
	parameter int CHANNELS   = CHANNELS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    channel,
	input  logic signed [DATA_WIDTH-1:0]  sample,
	input  logic signed [DATA_WIDTH-1:0]  weight_oldest,
	input  logic signed [DATA_WIDTH-1:0]  weight_middle,
	input  logic signed [DATA_WIDTH-1:0]  weight_recent,
	input  logic signed [DATA_WIDTH-1:0]  weight_current,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    channel_out,
	output logic signed [DATA_WIDTH-1:0]  activation
);

	logic                      busy;
	logic                      q_valid;
	logic                      q_pop;
	ctl_t                      q_ctl;
	logic [5*DATA_WIDTH-1:0]   q_data;

	// front: take and classify items
	ccs_front #(
		.CHANNELS  (CHANNELS),
		.DATA_WIDTH(DATA_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.channel       (channel),
		.sample        (sample),
		.weight_oldest (weight_oldest),
		.weight_middle (weight_middle),
		.weight_recent (weight_recent),
		.weight_current(weight_current),
		.busy          (busy),
		.q_valid       (q_valid),
		.q_ctl         (q_ctl),
		.q_data        (q_data),
		.q_pop         (q_pop)
	);

	// back: history, arithmetic, result register
	ccs_back #(
		.CHANNELS  (CHANNELS),
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_ctl      (q_ctl),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.busy       (busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.channel_out(channel_out),
		.activation (activation)
	);

	// no item taken while the history is being cleared
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready)
		else $error("item accepted during history clear");

	// the back end only pops a filled queue outside the clear
	a_pop_legal: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_valid && !busy))
		else $error("queue popped while empty or clearing");

	// an out of range channel always yields zero
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (32'(channel_out) >= 32'(CHANNELS))) |-> (activation == '0))
		else $error("nonzero result for out of range channel");

endmodule

FILE: bench/causal_conv1d_silu_chk.sv
// checker for the causal conv1d silu block: predicts each result and compares
module causal_conv1d_silu_chk import ccs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [7:0]               channel,
	input  logic signed [15:0]       sample,
	input  logic signed [15:0]       weight_oldest,
	input  logic signed [15:0]       weight_middle,
	input  logic signed [15:0]       weight_recent,
	input  logic signed [15:0]       weight_current,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [7:0]               channel_out,
	input  logic signed [15:0]       activation,
	output int                       fail_count,
	output int                       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0]         ch;
		logic signed [15:0] act;
	} conv_result_t;

	localparam longint LOG2E  = 64'sd387270501;
	localparam longint C1     = 64'sd744261139;
	localparam longint C2     = 64'sd257941240;
	localparam longint C3     = 64'sd59597074;
	localparam longint C4     = 64'sd10327356;
	localparam longint UNITY  = 64'sd1 << 30;
	localparam longint ACT_LIM = 64'sd32 << FRAC_BITS;

	logic signed [15:0] taps_hist [CHANNELS_DEF][3];
	conv_result_t       result_fifo [$];

	// 64-bit add clamped at both ends
	function automatic longint clamp_add(longint x, longint y);
		logic signed [64:0] s;
		s = 65'(x) + 65'(y);
		if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
		if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return longint'(s);
	endfunction

	// silu of a q.12 value through a 2^n times quartic exp split
	function automatic longint swish_q12(longint a);
		longint z, n, f, t, p, num;
		logic [63:0] d, mag;
		if (a >= ACT_LIM) return a;
		if (a <= -ACT_LIM) return 0;
		z = (-a * LOG2E) >>> 24;
		if (z >= 0) n = (z + 32768) >>> 16;
		else n = -((-z + 32768) >>> 16);
		f = z - n * 65536;
		t = C4;
		t = C3 + ((f * t) >>> 16);
		t = C2 + ((f * t) >>> 16);
		t = C1 + ((f * t) >>> 16);
		p = UNITY + ((f * t) >>> 16);
		if (n > 30) return 0;
		if (n <= 0) d = 64'(UNITY) + (64'(p) >> (-n));
		else d = 64'(UNITY) + (64'(p) << n);
		num = a * UNITY;
		mag = (num >= 0) ? 64'(num) : 64'(-num);
		mag = (2 * mag + d) / (2 * d);
		return (num >= 0) ? longint'(mag) : -longint'(mag);
	endfunction

	// one item: tap sum, activation, history shift
	function automatic conv_result_t conv_step(logic [7:0] ch, logic signed [15:0] x,
			logic signed [15:0] w0, logic signed [15:0] w1, logic signed [15:0] w2,
			logic signed [15:0] w3);
		conv_result_t r;
		longint acc, y;
		acc = 0;
		acc = clamp_add(acc, longint'(w0) * longint'(taps_hist[ch][0]));
		acc = clamp_add(acc, longint'(w1) * longint'(taps_hist[ch][1]));
		acc = clamp_add(acc, longint'(w2) * longint'(taps_hist[ch][2]));
		acc = clamp_add(acc, longint'(w3) * longint'(x));
		y = swish_q12(acc >>> FRAC_BITS);
		if (y > 32767) y = 32767;
		if (y < -32768) y = -32768;
		r.ch = ch;
		r.act = 16'(y);
		taps_hist[ch][0] = taps_hist[ch][1];
		taps_hist[ch][1] = taps_hist[ch][2];
		taps_hist[ch][2] = x;
		return r;
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
		for (int i = 0; i < CHANNELS_DEF; i++) begin
			for (int k = 0; k < 3; k++) taps_hist[i][k] = '0;
		end
	end

	// watch both channels
	always @(posedge clk) begin
		conv_result_t e;
		if (arst_n && in_valid && in_ready)
			result_fifo.push_back(conv_step(channel, sample, weight_oldest, weight_middle,
				weight_recent, weight_current));
		if (arst_n && out_valid && out_ready) begin
			if (result_fifo.size() == 0) begin
				$error("result item with nothing expected: channel_out %0d", channel_out);
				fail_count++;
			end else begin
				e = result_fifo.pop_front();
				if (channel_out !== e.ch) begin
					$error("channel_out expected %0d actual %0d", e.ch, channel_out);
					fail_count++;
				end
				if (activation !== e.act) begin
					$error("activation expected %0d actual %0d", e.act, activation);
					fail_count++;
				end
			end
		end
		pending = result_fifo.size();
	end

endmodule

FILE: bench/causal_conv1d_silu_tb.sv
// stimulus and verdict for the causal conv1d silu block
module causal_conv1d_silu_tb;
	import ccs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         channel = '0;
	logic signed [15:0] sample = '0;
	logic signed [15:0] weight_oldest = '0;
	logic signed [15:0] weight_middle = '0;
	logic signed [15:0] weight_recent = '0;
	logic signed [15:0] weight_current = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [7:0]         channel_out;
	logic signed [15:0] activation;
	int                 fail_count;
	int                 pending;
	bit                 gaps_on = 1'b1;
	bit                 hold_go = 1'b0;
	int                 quiet_cycles = 0;

	causal_conv1d_silu dut (.*);

	causal_conv1d_silu_chk chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// one item on the input channel, with an occasional gap first
	task automatic send_item(logic [7:0] ch, logic signed [15:0] x, logic signed [15:0] w0,
			logic signed [15:0] w1, logic signed [15:0] w2, logic signed [15:0] w3);
		while (gaps_on && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		channel <= ch;
		sample <= x;
		weight_oldest <= w0;
		weight_middle <= w1;
		weight_recent <= w2;
		weight_current <= w3;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_word(bit wide);
		return wide ? 16'($urandom) : 16'($urandom_range(0, 16383) - 8192);
	endfunction

	// receiver: random stalls, plus one long hold on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
			end
			out_ready <= !(gaps_on && $urandom_range(99) < 6);
		end
	end

	// watchdog on cycles with no item moving
	initial begin
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= 3000) begin
				$display("causal_conv1d_silu verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] ch;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, saturation both ways, deep negative, small sums
		send_item(8'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_item(8'd0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_item(8'd0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000);
		send_item(8'd0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
		send_item(8'd255, 16'sh7fff, 0, 0, 0, 16'sh7fff);
		send_item(8'd255, 16'sh7fff, 0, 0, 0, 16'sh8000);
		send_item(8'd1, -16'sd12288, 0, 0, 0, 16'sh7fff);
		send_item(8'd1, -16'sd4096, 0, 0, 16'sd4096, 16'sd4096);
		send_item(8'd2, 16'sd4096, 0, 0, 0, 16'sd4096);
		send_item(8'd2, -16'sd4096, 0, 0, 0, 16'sd4096);
		send_item(8'd3, 16'sd1, 0, 0, 0, 16'sd1);
		send_item(8'd3, 16'sd8192, 16'sd4096, 16'sd4096, 16'sd4096, 16'sd4096);
		send_item(8'd3, 16'sd16384, 16'sd4096, 16'sd4096, 16'sd4096, 16'sd8192);
		send_item(8'd3, -16'sd20480, 16'sd4096, 16'sd4096, 16'sd4096, 16'sd8192);
		send_item(8'd4, 16'sd2048, 0, 0, 0, -16'sd8192);
		send_item(8'd128, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);
		send_item(8'd128, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);

		// random: mostly a few busy channels with moderate values
		for (int i = 0; i < 500; i++) begin
			if (i == 100) hold_go = 1'b1;
			if (i == 200) begin
				// pause the sender until every result is out
				in_valid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
			if (i == 250) gaps_on = 1'b0;
			if (i == 350) gaps_on = 1'b1;
			ch = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(5, 12));
			send_item(ch, rand_word($urandom_range(3) == 0), rand_word($urandom_range(3) == 0),
				rand_word($urandom_range(3) == 0), rand_word($urandom_range(3) == 0),
				rand_word($urandom_range(3) == 0));
		end
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (60) @(posedge clk);
		if (fail_count == 0) begin
			$display("causal_conv1d_silu verification clean");
		end else begin
			$display("causal_conv1d_silu verification failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/ccs_pkg.sv
hdl/ccs_front.sv
hdl/ccs_hist.sv
hdl/ccs_div.sv
hdl/ccs_back.sv
hdl/causal_conv1d_silu.sv
bench/causal_conv1d_silu_chk.sv
bench/causal_conv1d_silu_tb.sv
